// ===== src/dihedral_angle_from_four_points_core_assert.svh =====
// Assertion macros shared by the core.
`ifndef DIHEDRAL_ANGLE_FROM_FOUR_POINTS_CORE_ASSERT_SVH
`define DIHEDRAL_ANGLE_FROM_FOUR_POINTS_CORE_ASSERT_SVH

// Same-cycle implication.
`define DAFP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DAFP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dafp_pkg.sv =====
package dafp_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int NUM_COORDS      = 12;
   localparam int REQ_DATA_W      = COORD_WIDTH * NUM_COORDS;
   localparam int DIFF_W          = COORD_WIDTH + 1;
   localparam int PROD_W          = 2 * DIFF_W;
   localparam int CROSS_W         = PROD_W + 1;
   localparam int LEN_W           = $clog2(CROSS_W + 1);
   localparam int NORM_BITS       = 30;
   localparam int M_W             = NORM_BITS + 1;
   localparam int MP_W            = 2 * M_W;
   localparam int WIDE_W          = 64;
   localparam int CR_W            = 34;
   localparam int CORD_W          = 48;
   localparam int STEPS           = 32;
   localparam int STEP_W          = $clog2(STEPS);
   localparam int ANGLE_FRAC_BITS = 14;
   localparam int ANGLE_W         = ANGLE_FRAC_BITS + 2;
   localparam int CODE_SHIFT      = 60 - ANGLE_FRAC_BITS;
   localparam int FRONT_STAGES    = 10;

   localparam logic [WIDE_W-1:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [WIDE_W-1:0] HALF_LSB = 64'd1 << (CODE_SHIFT - 1);
   localparam logic [WIDE_W-1:0] MAX_CODE = (PI_Q60 + HALF_LSB) >> CODE_SHIFT;

   typedef struct packed {
      logic                     deg;
      logic [WIDE_W-1:0]        rem;
      logic [WIDE_W-1:0]        root;
      logic signed [CORD_W-1:0] x;
   } sqrt_type;

   typedef struct packed {
      logic                     deg;
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic signed [WIDE_W-1:0] z;
   } cordic_type;

   function automatic logic [WIDE_W-1:0] atan_q60(input int step);
      logic [WIDE_W-1:0] sum;
      logic [WIDE_W-1:0] term;
      int                k;
      int                e;
      sum = '0;
      if (step == 0) begin
         sum = PI_Q60 >> 2;
      end else begin
         for (k = 0; k < 31; k++) begin
            e = step * (2 * k + 1);
            if (e <= 60) begin
               term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
               if (k % 2 == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
      end
      return sum;
   endfunction

endpackage

// ===== src/dafp_sqrt_cell.sv =====
module dafp_sqrt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [dafp_pkg::STEP_W-1:0]   step,
   input  logic                          in_valid,
   input  dafp_pkg::sqrt_type            in_data,
   output logic                          out_valid,
   output dafp_pkg::sqrt_type            out_data
);

   logic                          valid_ff;
   dafp_pkg::sqrt_type            data_ff;
   dafp_pkg::sqrt_type            data_in;
   logic [dafp_pkg::WIDE_W-1:0]   bit_w;
   logic [dafp_pkg::WIDE_W-1:0]   trial;
   logic [5:0]                    sh;

   always_comb begin
      sh      = 6'd62 - {step, 1'b0};
      bit_w   = 64'd1 << sh;
      trial   = in_data.root + bit_w;
      data_in = in_data;
      if (in_data.rem >= trial) begin
         data_in.rem  = in_data.rem - trial;
         data_in.root = (in_data.root >> 1) + bit_w;
      end else begin
         data_in.root = in_data.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/dafp_cordic_cell.sv =====
module dafp_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [dafp_pkg::STEP_W-1:0]   step,
   input  logic [dafp_pkg::WIDE_W-1:0]   atan,
   input  logic                          in_valid,
   input  dafp_pkg::cordic_type          in_data,
   output logic                          out_valid,
   output dafp_pkg::cordic_type          out_data
);

   logic                               valid_ff;
   dafp_pkg::cordic_type               data_ff;
   dafp_pkg::cordic_type               data_in;
   logic signed [dafp_pkg::CORD_W-1:0] xv;
   logic signed [dafp_pkg::CORD_W-1:0] yv;
   logic signed [dafp_pkg::CORD_W-1:0] dx;
   logic signed [dafp_pkg::CORD_W-1:0] dy;
   logic signed [dafp_pkg::WIDE_W-1:0] zv;

   always_comb begin
      xv      = in_data.x;
      yv      = in_data.y;
      zv      = in_data.z;
      dx      = yv >>> step;
      dy      = xv >>> step;
      data_in = in_data;
      if (yv > 0) begin
         data_in.x = xv + dx;
         data_in.y = yv - dy;
         data_in.z = zv + $signed(atan);
      end else begin
         data_in.x = xv - dx;
         data_in.y = yv + dy;
         data_in.z = zv - $signed(atan);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/dihedral_angle_from_four_points_core.sv =====
// Pipeline from request accept to result valid: 10 front stages, 32 square-root
// cells, one swap stage, 32 CORDIC cells and one output register.
// Throughput: one request per cycle; the whole pipe holds only while a result
// waits on rsp_tready.
// Reset: synchronous, active high; clears every valid bit, no data is kept.
module dihedral_angle_from_four_points_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // origin_x, origin_y, origin_z, origin_next_x, origin_next_y, origin_next_z,
   // far_x, far_y, far_z, far_next_x, far_next_y, far_next_z (32 bits each)
   input  logic [dafp_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // angle
   output logic [dafp_pkg::ANGLE_W-1:0]      rsp_tdata,
   // degenerate
   output logic                              rsp_tuser
);

   `include "dihedral_angle_from_four_points_core_assert.svh"

   localparam int DW = dafp_pkg::DIFF_W;
   localparam int PW = dafp_pkg::PROD_W;
   localparam int CW = dafp_pkg::CROSS_W;
   localparam int MW = dafp_pkg::M_W;
   localparam int QW = dafp_pkg::MP_W;
   localparam int WW = dafp_pkg::WIDE_W;
   localparam int KW = dafp_pkg::CORD_W;
   localparam int RW = dafp_pkg::CR_W;
   localparam int SN = dafp_pkg::STEPS;
   localparam int CWD = dafp_pkg::COORD_WIDTH;

   logic adv;
   logic [dafp_pkg::FRONT_STAGES-1:0] valid_ff;

   logic signed [CWD-1:0] co [dafp_pkg::NUM_COORDS];
   logic signed [DW-1:0] a_ff [3], b_ff [3], p_ff [3], q_ff [3];
   logic signed [PW-1:0] prod_ff [2][6];
   logic signed [CW-1:0] cross_ff [2][3];
   logic [CW-1:0]        mag_ff [2][3];
   logic                 neg_ff [2][3];
   logic [CW-1:0]        mag2_ff [2][3];
   logic                 neg2_ff [2][3];
   logic [dafp_pkg::LEN_W-1:0] len_ff [2];
   logic [dafp_pkg::LEN_W-1:0] len_in [2];
   logic [CW-1:0]        orv [2];
   logic signed [MW-1:0] m_ff [2][3];
   logic [dafp_pkg::NORM_BITS-1:0] shv [2][3];
   logic                 deg5_ff, deg6_ff, deg7_ff, deg8_ff, deg9_ff;
   logic signed [QW-1:0] mp_ff [9];
   logic signed [WW-1:0] dot_ff;
   logic signed [WW-1:0] crd [3];
   logic signed [RW-1:0] cr_ff [3];
   logic signed [WW-1:0] negdot;
   logic signed [WW-1:0] xsh;
   logic signed [KW-1:0] x8_ff, x9_ff;
   logic signed [2*RW-1:0] sqf [3];
   logic [WW-1:0]        sqr_ff [3];
   logic [WW-1:0]        sq_ff;

   logic                 sq_valid [SN+1];
   dafp_pkg::sqrt_type   sq_data  [SN+1];
   logic                 cd_valid [SN+1];
   dafp_pkg::cordic_type cd_data  [SN+1];
   logic                 rot_valid_ff;
   dafp_pkg::cordic_type rot_ff;
   dafp_pkg::cordic_type rot_in;

   logic                    rsp_tvalid_ff;
   logic [dafp_pkg::ANGLE_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_tuser_ff;
   logic [WW-1:0]           zc;
   logic [WW-1:0]           code;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[dafp_pkg::FRONT_STAGES-2:0], req_tvalid};
      end
   end

   always_comb begin
      for (int i = 0; i < dafp_pkg::NUM_COORDS; i++) begin
         co[i] = req_tdata[i*CWD +: CWD];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= DW'(co[6+i]) - DW'(co[i]);
            b_ff[i] <= DW'(co[3+i]) - DW'(co[i]);
            p_ff[i] <= DW'(co[i]) - DW'(co[6+i]);
            q_ff[i] <= DW'(co[9+i]) - DW'(co[6+i]);
         end
         prod_ff[0][0] <= a_ff[1] * b_ff[2];
         prod_ff[0][1] <= a_ff[2] * b_ff[1];
         prod_ff[0][2] <= a_ff[2] * b_ff[0];
         prod_ff[0][3] <= a_ff[0] * b_ff[2];
         prod_ff[0][4] <= a_ff[0] * b_ff[1];
         prod_ff[0][5] <= a_ff[1] * b_ff[0];
         prod_ff[1][0] <= p_ff[1] * q_ff[2];
         prod_ff[1][1] <= p_ff[2] * q_ff[1];
         prod_ff[1][2] <= p_ff[2] * q_ff[0];
         prod_ff[1][3] <= p_ff[0] * q_ff[2];
         prod_ff[1][4] <= p_ff[0] * q_ff[1];
         prod_ff[1][5] <= p_ff[1] * q_ff[0];
         for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
               cross_ff[v][i] <= CW'(prod_ff[v][2*i]) - CW'(prod_ff[v][2*i+1]);
               neg_ff[v][i]   <= cross_ff[v][i][CW-1];
               mag_ff[v][i]   <= cross_ff[v][i][CW-1] ? -cross_ff[v][i] : cross_ff[v][i];
               mag2_ff[v][i]  <= mag_ff[v][i];
               neg2_ff[v][i]  <= neg_ff[v][i];
            end
            len_ff[v] <= len_in[v];
         end
      end
   end

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         orv[v]    = mag_ff[v][0] | mag_ff[v][1] | mag_ff[v][2];
         len_in[v] = '0;
         for (int k = 0; k < CW; k++) begin
            if (orv[v][k]) begin
               len_in[v] = dafp_pkg::LEN_W'(k + 1);
            end
         end
         for (int i = 0; i < 3; i++) begin
            if (len_ff[v] >= dafp_pkg::LEN_W'(dafp_pkg::NORM_BITS)) begin
               shv[v][i] = dafp_pkg::NORM_BITS'(mag2_ff[v][i] >>
                           (len_ff[v] - dafp_pkg::LEN_W'(dafp_pkg::NORM_BITS)));
            end else begin
               shv[v][i] = dafp_pkg::NORM_BITS'(mag2_ff[v][i] <<
                           (dafp_pkg::LEN_W'(dafp_pkg::NORM_BITS) - len_ff[v]));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
               m_ff[v][i] <= neg2_ff[v][i] ? -$signed({1'b0, shv[v][i]})
                                           : $signed({1'b0, shv[v][i]});
            end
         end
         deg5_ff <= (len_ff[0] == '0) || (len_ff[1] == '0);
         mp_ff[0] <= m_ff[0][0] * m_ff[1][0];
         mp_ff[1] <= m_ff[0][1] * m_ff[1][1];
         mp_ff[2] <= m_ff[0][2] * m_ff[1][2];
         mp_ff[3] <= m_ff[0][1] * m_ff[1][2];
         mp_ff[4] <= m_ff[0][2] * m_ff[1][1];
         mp_ff[5] <= m_ff[0][2] * m_ff[1][0];
         mp_ff[6] <= m_ff[0][0] * m_ff[1][2];
         mp_ff[7] <= m_ff[0][0] * m_ff[1][1];
         mp_ff[8] <= m_ff[0][1] * m_ff[1][0];
         deg6_ff <= deg5_ff;
         dot_ff  <= WW'(mp_ff[0]) + WW'(mp_ff[1]) + WW'(mp_ff[2]);
         for (int i = 0; i < 3; i++) begin
            cr_ff[i] <= RW'(crd[i] >>> dafp_pkg::NORM_BITS);
         end
         deg7_ff <= deg6_ff;
         x8_ff   <= KW'(xsh);
         for (int i = 0; i < 3; i++) begin
            sqr_ff[i] <= WW'(sqf[i]);
         end
         deg8_ff <= deg7_ff;
         sq_ff   <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
         x9_ff   <= x8_ff;
         deg9_ff <= deg8_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         crd[i] = WW'(mp_ff[3+2*i]) - WW'(mp_ff[4+2*i]);
         sqf[i] = cr_ff[i] * cr_ff[i];
      end
      negdot = -dot_ff;
      xsh    = negdot >>> dafp_pkg::NORM_BITS;
   end

   assign sq_valid[0]     = valid_ff[dafp_pkg::FRONT_STAGES-1];
   assign sq_data[0].deg  = deg9_ff;
   assign sq_data[0].rem  = sq_ff;
   assign sq_data[0].root = '0;
   assign sq_data[0].x    = x9_ff;

   for (genvar s = 0; s < SN; s++) begin : g_sqrt
      dafp_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step      (dafp_pkg::STEP_W'(s)),
         .in_valid  (sq_valid[s]),
         .in_data   (sq_data[s]),
         .out_valid (sq_valid[s+1]),
         .out_data  (sq_data[s+1])
      );
   end

   always_comb begin
      rot_in.deg = sq_data[SN].deg;
      if (sq_data[SN].x < 0) begin
         rot_in.x = KW'(sq_data[SN].root);
         rot_in.y = -sq_data[SN].x;
         rot_in.z = $signed(dafp_pkg::PI_Q60 >> 1);
      end else begin
         rot_in.x = sq_data[SN].x;
         rot_in.y = KW'(sq_data[SN].root);
         rot_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_valid_ff <= 1'b0;
      end else if (adv) begin
         rot_valid_ff <= sq_valid[SN];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_ff <= rot_in;
      end
   end

   assign cd_valid[0] = rot_valid_ff;
   assign cd_data[0]  = rot_ff;

   for (genvar s = 0; s < SN; s++) begin : g_cordic
      localparam logic [WW-1:0] ATAN_C = dafp_pkg::atan_q60(s);
      dafp_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step      (dafp_pkg::STEP_W'(s)),
         .atan      (ATAN_C),
         .in_valid  (cd_valid[s]),
         .in_data   (cd_data[s]),
         .out_valid (cd_valid[s+1]),
         .out_data  (cd_data[s+1])
      );
   end

   always_comb begin
      zc   = cd_data[SN].z[WW-1] ? '0 : cd_data[SN].z;
      code = (zc + dafp_pkg::HALF_LSB) >> dafp_pkg::CODE_SHIFT;
      if (code > dafp_pkg::MAX_CODE) begin
         code = dafp_pkg::MAX_CODE;
      end
      rsp_tdata_in = cd_data[SN].deg ? '0 : dafp_pkg::ANGLE_W'(code);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= cd_valid[SN];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= cd_data[SN].deg;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `DAFP_ASSERT_IMP(a_deg_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "degenerate angle not zero")
   `DAFP_ASSERT_IMP(a_code_max, rsp_tvalid, {48'd0, rsp_tdata} <= dafp_pkg::MAX_CODE, "angle above pi")
   `DAFP_ASSERT_NXT(a_out_load, cd_valid[SN] && adv, rsp_tvalid, "result dropped at output")

endmodule
